[hw/rtl/slm_pkg.sv]
// shared constants, types and codes for the sorted list merge block
package slm_pkg;

	localparam int LIST_DEPTH = 32;
	localparam int DATA_WIDTH = 32;
	localparam int OP_WIDTH   = 2;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CQ_DEPTH   = 2;
	localparam int CQ_PTR_W   = 1;
	localparam int CQ_CNT_W   = 2;

	localparam logic [OP_WIDTH-1:0] OP_APPEND_A = 2'd0;
	localparam logic [OP_WIDTH-1:0] OP_APPEND_B = 2'd1;
	localparam logic [OP_WIDTH-1:0] OP_MERGE    = 2'd2;

	typedef enum logic [1:0] {
		CMD_APPEND_A,
		CMD_APPEND_B,
		CMD_MERGE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t              kind;
		logic [DATA_WIDTH-1:0] value;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_MERGE
	} back_state_t;

endpackage

[hw/rtl/slm_front.sv]
// front part: accepts items, decodes the operation and queues commands
module slm_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [slm_pkg::OP_WIDTH-1:0]   operation,
	input  logic [slm_pkg::DATA_WIDTH-1:0] value,
	output logic                           cmd_valid,
	input  logic                           cmd_ready,
	output slm_pkg::cmd_t                  cmd
);

	slm_pkg::cmd_t                 queue_q [slm_pkg::CQ_DEPTH];
	logic [slm_pkg::CQ_PTR_W-1:0]  wr_ptr_q;
	logic [slm_pkg::CQ_PTR_W-1:0]  rd_ptr_q;
	logic [slm_pkg::CQ_CNT_W-1:0]  cnt_q;
	slm_pkg::cmd_t                 dec_cmd;
	logic                          dec_ok;
	logic                          enq;
	logic                          deq;

	always_comb begin
		dec_cmd.value = value;
		dec_cmd.kind  = slm_pkg::CMD_APPEND_A;
		dec_ok        = 1'b1;
		case (operation)
			slm_pkg::OP_APPEND_A: dec_cmd.kind = slm_pkg::CMD_APPEND_A;
			slm_pkg::OP_APPEND_B: dec_cmd.kind = slm_pkg::CMD_APPEND_B;
			slm_pkg::OP_MERGE:    dec_cmd.kind = slm_pkg::CMD_MERGE;
			default:              dec_ok       = 1'b0;
		endcase
	end

	assign full      = (cnt_q == slm_pkg::CQ_CNT_W'(slm_pkg::CQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = queue_q[rd_ptr_q];
	assign enq       = push && !full && dec_ok;
	assign deq       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (enq) begin
			queue_q[wr_ptr_q] <= dec_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({enq, deq})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/slm_back.sv]
// back part: list stores, append execution and the merge engine
module slm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  slm_pkg::cmd_t                  cmd,
	output logic                           empty,
	input  logic                           pop,
	output logic [slm_pkg::DATA_WIDTH-1:0] merged_value,
	output logic                           last
);

	logic [slm_pkg::DATA_WIDTH-1:0] mem_a [slm_pkg::LIST_DEPTH];
	logic [slm_pkg::DATA_WIDTH-1:0] mem_b [slm_pkg::LIST_DEPTH];
	logic [slm_pkg::DATA_WIDTH-1:0] rd_a_q;
	logic [slm_pkg::DATA_WIDTH-1:0] rd_b_q;

	slm_pkg::back_state_t        state_q, state_d;
	logic [slm_pkg::CNT_W-1:0]   count_a_q, count_a_d;
	logic [slm_pkg::CNT_W-1:0]   count_b_q, count_b_d;
	logic [slm_pkg::CNT_W-1:0]   ia_q, ia_d;
	logic [slm_pkg::CNT_W-1:0]   ib_q, ib_d;
	logic [slm_pkg::DATA_WIDTH-1:0] out_value_q;
	logic                        out_last_q;
	logic                        out_valid_q;

	logic                        wr_a;
	logic                        wr_b;
	logic                        a_left;
	logic                        b_left;
	logic                        take_a;
	logic                        emit;
	logic                        emit_last;
	logic [slm_pkg::DATA_WIDTH-1:0] pick;
	logic                        out_free;

	assign out_free  = !out_valid_q || pop;
	assign cmd_ready = (state_q == slm_pkg::ST_IDLE);
	assign a_left    = (ia_q < count_a_q);
	assign b_left    = (ib_q < count_b_q);
	assign take_a    = (a_left && b_left) ? ($signed(rd_a_q) < $signed(rd_b_q)) : a_left;
	assign pick      = take_a ? rd_a_q : rd_b_q;

	always_comb begin
		state_d   = state_q;
		count_a_d = count_a_q;
		count_b_d = count_b_q;
		ia_d      = ia_q;
		ib_d      = ib_q;
		wr_a      = 1'b0;
		wr_b      = 1'b0;
		emit      = 1'b0;
		emit_last = 1'b0;
		case (state_q)
			slm_pkg::ST_IDLE: begin
				ia_d = '0;
				ib_d = '0;
				if (cmd_valid) begin
					case (cmd.kind)
						slm_pkg::CMD_APPEND_A: begin
							if (count_a_q < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH)) begin
								wr_a      = 1'b1;
								count_a_d = count_a_q + 1'b1;
							end
						end
						slm_pkg::CMD_APPEND_B: begin
							if (count_b_q < slm_pkg::CNT_W'(slm_pkg::LIST_DEPTH)) begin
								wr_b      = 1'b1;
								count_b_d = count_b_q + 1'b1;
							end
						end
						slm_pkg::CMD_MERGE: begin
							if ((count_a_q != '0) || (count_b_q != '0)) begin
								state_d = slm_pkg::ST_MERGE;
							end
						end
						default: state_d = slm_pkg::ST_IDLE;
					endcase
				end
			end
			slm_pkg::ST_MERGE: begin
				if (out_free) begin
					emit = 1'b1;
					if (take_a) begin
						ia_d = ia_q + 1'b1;
					end else begin
						ib_d = ib_q + 1'b1;
					end
					emit_last = !(ia_d < count_a_q) && !(ib_d < count_b_q);
					if (emit_last) begin
						state_d   = slm_pkg::ST_IDLE;
						count_a_d = '0;
						count_b_d = '0;
						ia_d      = '0;
						ib_d      = '0;
					end
				end
			end
			default: state_d = slm_pkg::ST_IDLE;
		endcase
	end

	// read data registered, addressed by the next head values so that it matches the heads
	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[count_a_q[slm_pkg::ADDR_W-1:0]] <= cmd.value;
		end
		if (wr_b) begin
			mem_b[count_b_q[slm_pkg::ADDR_W-1:0]] <= cmd.value;
		end
		rd_a_q <= mem_a[ia_d[slm_pkg::ADDR_W-1:0]];
		rd_b_q <= mem_b[ib_d[slm_pkg::ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_value_q <= pick;
			out_last_q  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slm_pkg::ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_a_q <= count_a_d;
			count_b_q <= count_b_d;
			ia_q      <= ia_d;
			ib_q      <= ib_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign empty        = !out_valid_q;
	assign merged_value = out_value_q;
	assign last         = out_last_q;

endmodule

[hw/rtl/sorted_list_merge.sv]
// top level of the sorted list merge block
//
//   channel   direction  handshake         fields
//   input     in         push / full       operation, value
//   result    out        empty / pop       merged_value, last
//
// appends run in the back part when idle; unused codes are dropped at decode
// a merge of n1 plus n2 elements primes the list reads when taken, then emits
// one element per cycle unless a result is held; each list store has one read port
// a two-entry command queue sits between the decode front and the back part
// arst_n clears counts, queue and control; list stores are not cleared
// a held result stalls the merge; appends keep queueing until the queue fills
module sorted_list_merge (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  logic [slm_pkg::OP_WIDTH-1:0]   operation,
	input  logic [slm_pkg::DATA_WIDTH-1:0] value,
	output logic                           empty,
	input  logic                           pop,
	output logic [slm_pkg::DATA_WIDTH-1:0] merged_value,
	output logic                           last
);

	logic          cmd_valid;
	logic          cmd_ready;
	slm_pkg::cmd_t cmd;

	slm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.operation (operation),
		.value     (value),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	slm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.empty        (empty),
		.pop          (pop),
		.merged_value (merged_value),
		.last         (last)
	);

endmodule
